### hw/rtl/gsc_pkg.sv
`timescale 1ns / 1ps

package gsc_pkg;

    localparam int SUM_WIDTH_DEF = 48;
    localparam int E_W           = 24;
    localparam int FRAC_W        = 17;
    localparam int CHI2_W        = 20;
    localparam int FACT_W        = 20;
    localparam int MAG_W         = 41;
    localparam int ACC_W         = 36;
    localparam int T_W           = 26;

    localparam logic [FRAC_W-1:0] FRAC_ONE     = 17'd65536;
    localparam logic [E_W-1:0]    AMP_LOW      = 24'd1024000;
    localparam logic [E_W-1:0]    AMP_MID      = 24'd1280000;
    localparam logic [E_W-1:0]    AMP_F2_LOW   = 24'd1792000;
    localparam logic [E_W-1:0]    AMP_F1_CLAMP = 24'd2560000;
    localparam logic [E_W-1:0]    AMP_F2_CLAMP = 24'd4608000;
    localparam logic [CHI2_W-1:0] CHI2_SMALL   = 20'd4000;
    localparam logic [CHI2_W-1:0] CHI2_LARGE   = 20'd96000;
    localparam logic signed [ACC_W-1:0] Q24_ONE = 36'sd16777216;

    typedef struct packed {
        logic              hit_found;
        logic [E_W-1:0]    calib_energy;
        logic [E_W-1:0]    recalib_energy;
        logic [FRAC_W-1:0] hit_fraction;
        logic [CHI2_W-1:0] hit_chi2;
        logic              gain6_switch;
        logic              gain1_switch;
        logic              last_hit;
        logic [E_W-1:0]    cluster_raw_energy;
        logic [E_W-1:0]    photon_energy;
    } t_hit;

    typedef struct packed {
        logic signed [FACT_W-1:0] correction_factor;
        logic [E_W-1:0]           corrected_energy;
    } t_res;

    typedef enum logic [1:0] {
        POLY_ONE,
        POLY_F1,
        POLY_F2,
        POLY_F3
    } t_poly;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_GAIN_INIT,
        OP_HORNER,
        OP_DIV_HIT,
        OP_ACCUM,
        OP_DIV_RATIO,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_DIV_DELTA,
        OP_FACTOR,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic found;
        logic last;
        logic zero;
        logic horner_done;
        logic div_busy;
        logic mul_done;
        logic out_free;
    } t_sts;

    // Polynomial coefficients in Q.24, index is the power of t.
    function automatic logic signed [ACC_W-1:0] gsc_coef(input t_poly sel,
                                                         input logic [2:0] idx);
        logic signed [ACC_W-1:0] c;
        c = Q24_ONE;
        case (sel)
            POLY_F1: begin
                case (idx)
                    3'd0: c = 36'sd952142;
                    3'd1: c = 36'sd167405868;
                    3'd2: c = -36'sd610805203;
                    3'd3: c = 36'sd893663585;
                    default: c = -36'sd464701414;
                endcase
            end
            POLY_F2: begin
                case (idx)
                    3'd0: c = 36'sd12921241;
                    3'd1: c = 36'sd19867058;
                    3'd2: c = -36'sd30801019;
                    default: c = 36'sd12337846;
                endcase
            end
            POLY_F3: begin
                case (idx)
                    3'd0: c = -36'sd40114323;
                    3'd1: c = 36'sd274079662;
                    default: c = -36'sd375718654;
                endcase
            end
            default: c = Q24_ONE;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/gsc_div.sv
`timescale 1ns / 1ps

module gsc_div #(
    parameter int NW = gsc_pkg::SUM_WIDTH_DEF + gsc_pkg::MAG_W,
    parameter int DW = gsc_pkg::SUM_WIDTH_DEF,
    parameter int KQ = gsc_pkg::SUM_WIDTH_DEF + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic [KQ-1:0] o_quot,
    output logic          o_sat
);
    localparam int CW = $clog2(KQ + 1);

    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [KQ-1:0] r_lo;
    logic [KQ-1:0] r_q;
    logic          r_sat;
    logic [DW:0]   w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_lo[KQ-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};

    // Quotient bits above KQ mean saturation; otherwise shift in one bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_d <= i_divisor;
            r_q <= '0;
            r_lo <= i_dividend[KQ-1:0];
            if (DW'(i_dividend[NW-1:KQ]) >= i_divisor) begin
                r_sat <= 1'b1;
                r_cnt <= '0;
            end else begin
                r_sat <= 1'b0;
                r_rem <= DW'(i_dividend[NW-1:KQ]);
                r_cnt <= CW'(KQ);
            end
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
            r_lo  <= {r_lo[KQ-2:0], 1'b0};
            r_q   <= {r_q[KQ-2:0], w_ge};
            r_rem <= w_ge ? DW'(w_trial - {1'b0, r_d}) : w_trial[DW-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_q;
    assign o_sat  = r_sat;

endmodule

### hw/rtl/gsc_ctrl.sv
`timescale 1ns / 1ps

module gsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hit_valid,
    output logic          o_hit_ready,
    input  gsc_pkg::t_sts i_sts,
    output gsc_pkg::t_op  o_op
);
    import gsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_GAIN, S_HORN, S_DIVH, S_DIVHW, S_ACC, S_FCHK, S_DIVR,
        S_DIVRW, S_MULI, S_MUL, S_DIVD, S_DIVDW, S_FACT, S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_comb begin
        n_state = r_state;
        n_op    = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_hit_valid) begin
                    n_state = S_GAIN;
                    n_op    = OP_GAIN_INIT;
                end
            end
            S_GAIN: begin
                if (i_sts.found) begin
                    n_state = S_HORN;
                    n_op    = OP_HORNER;
                end else if (i_sts.last) begin
                    n_state = S_FCHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HORN: begin
                if (i_sts.horner_done) begin
                    n_state = S_DIVH;
                    n_op    = OP_DIV_HIT;
                end else begin
                    n_op = OP_HORNER;
                end
            end
            S_DIVH: n_state = S_DIVHW;
            S_DIVHW: begin
                if (!i_sts.div_busy) begin
                    n_state = S_ACC;
                    n_op    = OP_ACCUM;
                end
            end
            S_ACC: n_state = i_sts.last ? S_FCHK : S_IDLE;
            S_FCHK: begin
                if (i_sts.zero) begin
                    n_state = S_FACT;
                    n_op    = OP_FACTOR;
                end else begin
                    n_state = S_DIVR;
                    n_op    = OP_DIV_RATIO;
                end
            end
            S_DIVR: n_state = S_DIVRW;
            S_DIVRW: begin
                if (!i_sts.div_busy) begin
                    n_state = S_MULI;
                    n_op    = OP_MUL_INIT;
                end
            end
            S_MULI: begin
                n_state = S_MUL;
                n_op    = OP_MUL_STEP;
            end
            S_MUL: begin
                if (i_sts.mul_done) begin
                    n_state = S_DIVD;
                    n_op    = OP_DIV_DELTA;
                end else begin
                    n_op = OP_MUL_STEP;
                end
            end
            S_DIVD: n_state = S_DIVDW;
            S_DIVDW: begin
                if (!i_sts.div_busy) begin
                    n_state = S_FACT;
                    n_op    = OP_FACTOR;
                end
            end
            S_FACT: begin
                n_state = S_EMIT;
                n_op    = OP_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_op = OP_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NOP;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_hit_ready = r_state == S_IDLE;
    assign o_op        = r_op;

endmodule

### hw/rtl/gsc_dp.sv
`timescale 1ns / 1ps

module gsc_dp #(
    parameter int SUM_WIDTH = gsc_pkg::SUM_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  gsc_pkg::t_hit i_hit,
    input  gsc_pkg::t_op  i_op,
    output gsc_pkg::t_sts o_sts,
    input  logic          i_res_ready,
    output logic          o_res_valid,
    output gsc_pkg::t_res o_res
);
    import gsc_pkg::*;

    localparam int KQ = SUM_WIDTH + 1;
    localparam int NW = SUM_WIDTH + MAG_W;
    localparam int DW = SUM_WIDTH;
    localparam logic [SUM_WIDTH-1:0] CAP = '1;
    localparam logic [MAG_W-1:0] RATIO_CAP = MAG_W'(1) << 40;
    localparam logic [20:0] DELTA_CAP = 21'd1048576;

    t_hit                     r_hit;
    t_poly                    r_sel;
    logic [T_W-1:0]           r_t;
    logic signed [ACC_W-1:0]  r_acc;
    logic [2:0]               r_hcnt;
    logic [MAG_W-1:0]         r_rf, r_cf;
    logic [SUM_WIDTH-1:0]     r_sum_cal, r_sum_rec, r_sum_cor;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_mag;
    logic [NW-1:0]            r_prod;
    logic [5:0]               r_mcnt;
    logic signed [FACT_W-1:0] r_factor;
    t_res                     r_out;
    logic                     r_out_valid;

    logic [FRAC_W-1:0]        w_frac;
    t_poly                    w_sel;
    logic [E_W-1:0]           w_x;
    logic [2:0]               w_deg;
    logic signed [62:0]       w_prod;
    logic signed [ACC_W-1:0]  w_g;
    logic                     w_start;
    logic [NW-1:0]            w_dividend;
    logic [DW-1:0]            w_divisor;
    logic                     w_busy, w_sat;
    logic [KQ-1:0]            w_quot;
    logic [MAG_W-1:0]         w_ratio;
    logic [20:0]              w_delta;
    logic signed [22:0]       w_fact;
    logic [42:0]              w_eprod;
    logic [E_W-1:0]           w_energy;
    logic                     w_out_free;

    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] s,
                                                     input logic [KQ-1:0] v,
                                                     input logic over);
        logic [SUM_WIDTH+1:0] t;
        t = {2'b00, s} + {1'b0, v};
        if (over || t > {2'b00, CAP}) begin
            return CAP;
        end
        return t[SUM_WIDTH-1:0];
    endfunction

    assign w_frac = (r_hit.hit_fraction > FRAC_ONE) ? FRAC_ONE : r_hit.hit_fraction;

    // Pick the gain curve from the switch flags, chi2 and amplitude.
    always_comb begin
        logic [E_W-1:0]    x;
        logic [CHI2_W-1:0] c2;
        x     = r_hit.recalib_energy;
        c2    = r_hit.hit_chi2;
        w_sel = POLY_ONE;
        if (r_hit.gain6_switch && !r_hit.gain1_switch) begin
            w_sel = (x > AMP_MID && c2 < CHI2_SMALL) ? POLY_ONE : POLY_F1;
        end else if (!r_hit.gain6_switch && r_hit.gain1_switch) begin
            if (c2 > CHI2_LARGE) begin
                w_sel = POLY_F1;
            end else begin
                w_sel = (x < AMP_LOW || x > AMP_F2_LOW) ? POLY_ONE : POLY_F3;
            end
        end else if (r_hit.gain6_switch && r_hit.gain1_switch) begin
            w_sel = POLY_F2;
        end
        w_x   = x;
        w_deg = 3'd0;
        case (w_sel)
            POLY_F1: begin
                if (x < AMP_LOW) begin
                    w_sel = POLY_ONE;
                end else begin
                    w_deg = 3'd4;
                    if (x > AMP_F1_CLAMP) w_x = AMP_F1_CLAMP;
                end
            end
            POLY_F2: begin
                if (x < AMP_F2_LOW) begin
                    w_sel = POLY_ONE;
                end else begin
                    w_deg = 3'd3;
                    if (x > AMP_F2_CLAMP) w_x = AMP_F2_CLAMP;
                end
            end
            POLY_F3: w_deg = 3'd2;
            default: w_deg = 3'd0;
        endcase
    end

    assign w_prod = r_acc * $signed({1'b0, r_t});
    assign w_g    = (r_acc <= 0) ? Q24_ONE : r_acc;

    always_comb begin
        w_start    = 1'b0;
        w_dividend = NW'({r_rf, 24'd0});
        w_divisor  = DW'(w_g[34:0]);
        case (i_op)
            OP_DIV_HIT: w_start = 1'b1;
            OP_DIV_RATIO: begin
                w_start    = 1'b1;
                w_dividend = NW'({r_sum_cor, 16'd0});
                w_divisor  = r_sum_rec;
            end
            OP_DIV_DELTA: begin
                w_start    = 1'b1;
                w_dividend = r_prod;
                w_divisor  = DW'({r_hit.cluster_raw_energy, 16'd0});
            end
            default: w_start = 1'b0;
        endcase
    end

    gsc_div #(.NW(NW), .DW(DW), .KQ(KQ)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_busy),
        .o_quot     (w_quot),
        .o_sat      (w_sat)
    );

    assign w_ratio = (w_sat || w_quot > KQ'(RATIO_CAP)) ? RATIO_CAP : w_quot[MAG_W-1:0];
    assign w_delta = (w_sat || w_quot > KQ'(DELTA_CAP)) ? DELTA_CAP : w_quot[20:0];

    always_comb begin
        w_fact = r_neg ? (23'sd65536 - $signed({2'b00, w_delta}))
                       : (23'sd65536 + $signed({2'b00, w_delta}));
        if (w_fact > 23'sd524287) w_fact = 23'sd524287;
        if (w_fact < -23'sd524288) w_fact = -23'sd524288;
    end

    assign w_eprod = r_factor[18:0] * r_hit.photon_energy;
    always_comb begin
        if (r_factor <= 0) begin
            w_energy = '0;
        end else if (w_eprod[42:16] > 27'(24'hFFFFFF)) begin
            w_energy = '1;
        end else begin
            w_energy = w_eprod[39:16];
        end
    end

    assign w_out_free = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt      <= '0;
            r_mcnt      <= '0;
            r_sum_cal   <= '0;
            r_sum_rec   <= '0;
            r_sum_cor   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) r_hit <= i_hit;
            // Drop valid on a taken result unless a new one is loaded this cycle.
            if (i_res_ready && i_op != OP_EMIT) r_out_valid <= 1'b0;
            case (i_op)
                OP_GAIN_INIT: begin
                    r_sel  <= w_sel;
                    r_t    <= T_W'({w_x, 2'b00});
                    r_acc  <= (w_sel == POLY_ONE) ? Q24_ONE : gsc_coef(w_sel, w_deg);
                    r_hcnt <= w_deg;
                    r_rf   <= MAG_W'(r_hit.recalib_energy * w_frac);
                    r_cf   <= MAG_W'(r_hit.calib_energy * w_frac);
                end
                OP_HORNER: begin
                    if (r_hcnt != 3'd0) begin
                        r_acc  <= gsc_coef(r_sel, r_hcnt - 3'd1) + $signed(w_prod[59:24]);
                        r_hcnt <= r_hcnt - 3'd1;
                    end
                end
                OP_ACCUM: begin
                    r_sum_cal <= sat_add(r_sum_cal, KQ'(r_cf), 1'b0);
                    r_sum_rec <= sat_add(r_sum_rec, KQ'(r_rf), 1'b0);
                    r_sum_cor <= sat_add(r_sum_cor, w_quot, w_sat);
                end
                OP_MUL_INIT: begin
                    r_neg  <= w_ratio < MAG_W'(65536);
                    r_mag  <= (w_ratio < MAG_W'(65536)) ? MAG_W'(65536) - w_ratio
                                                        : w_ratio - MAG_W'(65536);
                    r_prod <= '0;
                    r_mcnt <= 6'(MAG_W);
                end
                OP_MUL_STEP: begin
                    if (r_mcnt != 6'd0) begin
                        r_prod <= {r_prod[NW-2:0], 1'b0}
                                + (r_mag[MAG_W-1] ? NW'(r_sum_cal) : NW'(0));
                        r_mag  <= {r_mag[MAG_W-2:0], 1'b0};
                        r_mcnt <= r_mcnt - 6'd1;
                    end
                end
                OP_FACTOR: begin
                    r_factor <= o_sts.zero ? 20'sd65536 : w_fact[FACT_W-1:0];
                end
                OP_EMIT: begin
                    if (w_out_free) begin
                        r_out.correction_factor <= r_factor;
                        r_out.corrected_energy  <= w_energy;
                        r_out_valid <= 1'b1;
                        r_sum_cal   <= '0;
                        r_sum_rec   <= '0;
                        r_sum_cor   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.found       = r_hit.hit_found;
    assign o_sts.last        = r_hit.last_hit;
    assign o_sts.zero        = (r_sum_rec == '0) || (r_hit.cluster_raw_energy == '0);
    assign o_sts.horner_done = r_hcnt == 3'd0;
    assign o_sts.div_busy    = w_busy;
    assign o_sts.mul_done    = r_mcnt == 6'd0;
    assign o_sts.out_free    = w_out_free;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### hw/rtl/gain_switch_cluster_energy_correction.sv
`timescale 1ns / 1ps
// Gain-switch energy correction for one calorimeter cluster.
// Hit requests come in on i_hit (valid/ready); one request is taken when the
// block is idle. A found hit runs its gain curve through a shared Horner
// multiply (up to four steps) and divides its weighted amplitude by the gain
// in a radix-2 divider of SUM_WIDTH+1 steps; a missing hit skips both.
// On the hit flagged last_hit the block then forms the cluster factor: one
// more division, a 41-step shift-add multiply and a third division (a zero
// recalibrated sum or raw energy skips them for a factor of one), then places
// factor and corrected energy in the output register o_res under o_res_valid.
// The divider is the pacing unit for both per-hit and per-cluster work.
// The output register decouples the sides: new hits are taken while a
// result waits; only a later cluster result stalls until the receiver
// raises i_res_ready. Reset clears the three weighted sums and all control.
// Hits with hit_found low add nothing but a last one still yields a result.
module gain_switch_cluster_energy_correction #(
    parameter int SUM_WIDTH = gsc_pkg::SUM_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hit_valid,
    output logic          o_hit_ready,
    input  gsc_pkg::t_hit i_hit,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output gsc_pkg::t_res o_res
);
    import gsc_pkg::*;

    t_op  w_op;
    t_sts w_sts;
    logic w_load;

    // Take a request only while the sequencer sits idle.
    assign w_load = i_hit_valid && o_hit_ready;

    gsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hit_valid (i_hit_valid),
        .o_hit_ready (o_hit_ready),
        .i_sts       (w_sts),
        .o_op        (w_op)
    );

    gsc_dp #(.SUM_WIDTH(SUM_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_hit       (i_hit),
        .i_op        (w_op),
        .o_sts       (w_sts),
        .i_res_ready (i_res_ready),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // No new request while a division is still running.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.div_busy |-> !o_hit_ready)
        else $error("request accepted during division");

    // A taken request always takes the block out of idle, so o_hit_ready drops.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> !o_hit_ready)
        else $error("ready held after accept");

    // A result appears only from the emit command.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(w_op == OP_EMIT))
        else $error("result without emit");

endmodule
